// ===== hw/rtl/bearing_to_goal_angle_defines.svh =====
// Assertion macros for the bearing-to-goal RTL.
// No dependencies; included by bearing_to_goal_angle.sv, which carries concurrent assertions.
`ifndef BEARING_TO_GOAL_ANGLE_DEFINES_SVH
`define BEARING_TO_GOAL_ANGLE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BTGA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bearing_to_goal_angle: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BTGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bearing_to_goal_angle: next-cycle check failed");

`endif

// ===== hw/rtl/btga_pkg.sv =====
// Package for the bearing-to-goal block: widths, angle constants, arctangent table.
// No dependencies; used by every module of the block by scoped names.
package btga_pkg;

    // Default configuration
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // Datapath widths
    localparam int VEC_W       = 63;  // normalized vector components, signed
    localparam int ANG_W       = 26;  // angle accumulator, 1/65536 degree, signed
    localparam int SHIFT_W     = 6;   // normalizing left-shift amount
    localparam int BEARING_W   = 16;
    localparam int NORM_MSB    = 58;  // larger magnitude lands in [2^58, 2^59)
    localparam int FRONT_STAGES = 5;

    // Angle constants
    localparam int HALF_TURN_ANG = 180 * 65536;
    localparam int ROUND_HALF    = 256;
    localparam int ROUND_SHIFT   = 9;
    localparam int BEARING_MIN   = -23040;
    localparam int BEARING_MAX   = 23039;

    // atan(2^-i) in degrees times 65536
    localparam int TABLE_LEN = 24;
    localparam logic signed [ANG_W-1:0] ATAN_TBL [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // Vector and angle carried between CORDIC iterations
    typedef struct packed {
        logic signed [VEC_W-1:0] a;   // sine-like component
        logic signed [VEC_W-1:0] b;   // cosine-like component
        logic signed [ANG_W-1:0] z;   // accumulated angle
    } t_cordic;

endpackage

// ===== hw/rtl/btga_front.sv =====
// Front end: input register, coordinate deltas, half-plane turn, leading-one
// search and normalizing shift. Depends on btga_pkg.
module btga_front #(
    parameter int COORD_WIDTH = btga_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [btga_pkg::FRONT_STAGES-1:0]     i_en,
    input  logic signed [COORD_WIDTH-1:0]         i_goal_x,
    input  logic signed [COORD_WIDTH-1:0]         i_goal_y,
    input  logic signed [COORD_WIDTH-1:0]         i_robot_x,
    input  logic signed [COORD_WIDTH-1:0]         i_robot_y,
    output logic [btga_pkg::FRONT_STAGES-1:0]     o_valid,
    output btga_pkg::t_cordic                     o_vec
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int MSB_W = $clog2(COORD_WIDTH);

    logic [btga_pkg::FRONT_STAGES-1:0] r_v;

    logic signed [COORD_WIDTH-1:0] r_gx0, r_gy0, r_rx0, r_ry0;
    logic signed [DW-1:0]          r_dx1, r_dy1;
    logic signed [DW-1:0]          r_a2, r_b2, r_a3, r_b3;
    logic signed [btga_pkg::ANG_W-1:0] r_z2, r_z3;
    logic [COORD_WIDTH-1:0]        r_m2;
    logic [btga_pkg::SHIFT_W-1:0]  r_k3;
    btga_pkg::t_cordic             r_vec4;

    logic                          n_nonzero;
    logic signed [DW-1:0]          n_a, n_b;
    logic signed [btga_pkg::ANG_W-1:0] n_z;
    logic [DW-1:0]                 n_a_abs, n_b_abs;
    logic [COORD_WIDTH-1:0]        n_m;
    logic [MSB_W-1:0]              n_msb;
    logic [btga_pkg::SHIFT_W-1:0]  n_k;
    logic signed [btga_pkg::VEC_W-1:0] n_a_ext, n_b_ext;

    // Valid bits advance with their stages; drop transactions with equal positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (i_en[0]) r_v[0] <= i_valid;
            if (i_en[1]) r_v[1] <= r_v[0];
            if (i_en[2]) r_v[2] <= r_v[1] && n_nonzero;
            if (i_en[3]) r_v[3] <= r_v[2];
            if (i_en[4]) r_v[4] <= r_v[3];
        end
    end

    // Stage 0: capture coordinates
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_gx0 <= i_goal_x;
            r_gy0 <= i_goal_y;
            r_rx0 <= i_robot_x;
            r_ry0 <= i_robot_y;
        end
    end

    // Stage 1: form the deltas
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_dx1 <= DW'(r_gx0) - DW'(r_rx0);
            r_dy1 <= DW'(r_gy0) - DW'(r_ry0);
        end
    end

    // Stage 2: turn the lower half-plane by a half turn, pick the larger magnitude
    always_comb begin
        n_nonzero = (r_dx1 != '0) || (r_dy1 != '0);
        n_a = -r_dx1;
        n_b = r_dy1;
        n_z = '0;
        if (r_dy1 < 0) begin
            n_z = (n_a > 0) ? btga_pkg::ANG_W'(btga_pkg::HALF_TURN_ANG)
                            : -btga_pkg::ANG_W'(btga_pkg::HALF_TURN_ANG);
            n_a = -n_a;
            n_b = -n_b;
        end
        n_a_abs = n_a[DW-1] ? DW'(-n_a) : DW'(n_a);
        n_b_abs = n_b[DW-1] ? DW'(-n_b) : DW'(n_b);
        n_m = (n_a_abs > n_b_abs) ? n_a_abs[COORD_WIDTH-1:0] : n_b_abs[COORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_a2 <= n_a;
            r_b2 <= n_b;
            r_z2 <= n_z;
            r_m2 <= n_m;
        end
    end

    // Stage 3: find the leading one and derive the left-shift amount
    always_comb begin
        n_msb = '0;
        for (int j = 0; j < COORD_WIDTH; j++) begin
            if (r_m2[j]) n_msb = MSB_W'(j);
        end
        n_k = btga_pkg::SHIFT_W'(btga_pkg::NORM_MSB - int'(n_msb));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_a3 <= r_a2;
            r_b3 <= r_b2;
            r_z3 <= r_z2;
            r_k3 <= n_k;
        end
    end

    // Stage 4: normalize both components
    always_comb begin
        n_a_ext = btga_pkg::VEC_W'(r_a3);
        n_b_ext = btga_pkg::VEC_W'(r_b3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_vec4.a <= n_a_ext <<< r_k3;
            r_vec4.b <= n_b_ext <<< r_k3;
            r_vec4.z <= r_z3;
        end
    end

    assign o_valid = r_v;
    assign o_vec   = r_vec4;

endmodule

// ===== hw/rtl/btga_cordic_stage.sv =====
// One CORDIC vectoring iteration with its pipeline register.
// Depends on btga_pkg for the vector type and the arctangent table.
module btga_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  btga_pkg::t_cordic i_vec,
    output logic              o_valid,
    output btga_pkg::t_cordic o_vec
);

    logic                              r_v;
    btga_pkg::t_cordic                 r_vec;
    logic signed [btga_pkg::VEC_W-1:0] w_a, w_b, w_as, w_bs;
    logic signed [btga_pkg::ANG_W-1:0] w_z;
    btga_pkg::t_cordic                 n_vec;

    // Rotate toward the cosine axis by atan(2^-IDX)
    always_comb begin
        w_a  = i_vec.a;
        w_b  = i_vec.b;
        w_z  = i_vec.z;
        w_as = w_a >>> IDX;
        w_bs = w_b >>> IDX;
        if (!w_a[btga_pkg::VEC_W-1]) begin
            n_vec.b = w_b + w_as;
            n_vec.a = w_a - w_bs;
            n_vec.z = w_z + btga_pkg::ATAN_TBL[IDX];
        end else begin
            n_vec.b = w_b - w_as;
            n_vec.a = w_a + w_bs;
            n_vec.z = w_z - btga_pkg::ATAN_TBL[IDX];
        end
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_vec <= n_vec;
    end

    assign o_valid = r_v;
    assign o_vec   = r_vec;

endmodule

// ===== hw/rtl/btga_out.sv =====
// Output stage: round the angle to 1/128 degree, saturate, hold the result.
// Depends on btga_pkg.
module btga_out (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [btga_pkg::ANG_W-1:0]    i_z,
    output logic                                 o_valid,
    output logic signed [btga_pkg::BEARING_W-1:0] o_bearing
);

    localparam int RES_W = btga_pkg::ANG_W + 1 - btga_pkg::ROUND_SHIFT;

    logic                                  r_v;
    logic signed [btga_pkg::BEARING_W-1:0] r_bearing;
    logic signed [btga_pkg::ANG_W:0]       w_sum;
    logic signed [RES_W-1:0]               w_res;
    logic signed [btga_pkg::BEARING_W-1:0] n_bearing;

    // Round half up, then clamp to the half-open range
    always_comb begin
        w_sum = (btga_pkg::ANG_W + 1)'(i_z) + (btga_pkg::ANG_W + 1)'(btga_pkg::ROUND_HALF);
        w_res = $signed(w_sum[btga_pkg::ANG_W:btga_pkg::ROUND_SHIFT]);
        if (w_res > RES_W'(btga_pkg::BEARING_MAX)) begin
            n_bearing = btga_pkg::BEARING_W'(btga_pkg::BEARING_MAX);
        end else if (w_res < RES_W'(btga_pkg::BEARING_MIN)) begin
            n_bearing = btga_pkg::BEARING_W'(btga_pkg::BEARING_MIN);
        end else begin
            n_bearing = w_res[btga_pkg::BEARING_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_bearing <= n_bearing;
    end

    assign o_valid   = r_v;
    assign o_bearing = r_bearing;

endmodule

// ===== hw/rtl/bearing_to_goal_angle.sv =====
// Bearing from robot to goal: top level joining front end, CORDIC pipeline and output.
// Depends on btga_pkg, btga_front, btga_cordic_stage, btga_out and the defines header.
//
// Usage:
//   Input channel: i_in_valid with i_goal_x, i_goal_y, i_robot_x, i_robot_y;
//   a transaction is taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with o_bearing (signed, 1/128 degree, zero at
//   north, counterclockwise positive, range [-23040, 23039]); taken when
//   i_out_stall is low.
//   The pipeline is five front-end stages, one register per CORDIC iteration
//   and one output register.
//   Throughput is one transaction per cycle unless the receiver stalls; every
//   stage is a register.
//   A transaction whose goal equals the robot position yields no result; its
//   slot becomes a bubble.
//   When the receiver stalls, a stage holds only while it and every stage after
//   it are full, so bubbles are squeezed out and the input keeps being taken
//   until the whole pipeline is full. o_in_stall then rises.
//   Synchronous reset clears all valid bits; the pipeline is empty afterwards.
`include "bearing_to_goal_angle_defines.svh"

module bearing_to_goal_angle #(
    parameter int COORD_WIDTH   = btga_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = btga_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_goal_x,
    input  logic signed [COORD_WIDTH-1:0]         i_goal_y,
    input  logic signed [COORD_WIDTH-1:0]         i_robot_x,
    input  logic signed [COORD_WIDTH-1:0]         i_robot_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [btga_pkg::BEARING_W-1:0] o_bearing
);

    localparam int FS = btga_pkg::FRONT_STAGES;
    localparam int NS = FS + CORDIC_STAGES;

    logic [NS-1:0]     w_v;
    logic [NS-1:0]     w_en;
    logic              w_out_en;
    btga_pkg::t_cordic w_vec [CORDIC_STAGES+1];

    // A stage advances unless it and everything downstream is full and blocked
    assign w_out_en = !o_out_valid || !i_out_stall;

    for (genvar j = 0; j < NS; j++) begin : g_en
        assign w_en[j] = ~(&w_v[NS-1:j]) | w_out_en;
    end

    assign o_in_stall = !w_en[0];

    // Front end
    btga_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_en      (w_en[FS-1:0]),
        .i_goal_x  (i_goal_x),
        .i_goal_y  (i_goal_y),
        .i_robot_x (i_robot_x),
        .i_robot_y (i_robot_y),
        .o_valid   (w_v[FS-1:0]),
        .o_vec     (w_vec[0])
    );

    // CORDIC iterations, one register each
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        btga_cordic_stage #(
            .IDX (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[FS+i]),
            .i_valid (w_v[FS+i-1]),
            .i_vec   (w_vec[i]),
            .o_valid (w_v[FS+i]),
            .o_vec   (w_vec[i+1])
        );
    end

    // Round, saturate and hold the result
    btga_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_out_en),
        .i_valid   (w_v[NS-1]),
        .i_z       (w_vec[CORDIC_STAGES].z),
        .o_valid   (o_out_valid),
        .o_bearing (o_bearing)
    );

    // Input is refused only while the output is held by the receiver
    `BTGA_ASSERT_SAME(a_stall_only_when_blocked, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // A new result comes only from a valid last CORDIC stage
    `BTGA_ASSERT_SAME(a_out_from_pipe, i_clk, i_rst_n, $rose(o_out_valid), $past(w_v[NS-1]))
    // Results stay in the bearing range
    `BTGA_ASSERT_SAME(a_bearing_range, i_clk, i_rst_n, o_out_valid, (o_bearing >= btga_pkg::BEARING_MIN) && (o_bearing <= btga_pkg::BEARING_MAX))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bearing_to_goal_angle: queue-fed driver, clocked monitor, bit-true
// CORDIC bearing predictor. Depends on btga_pkg and the bearing_to_goal_angle RTL.
module testbench;

    localparam int COORD_W     = 24;
    localparam int STAGES      = 16;
    localparam int LATENCY     = STAGES + 6;
    localparam int ATAN_LEN    = 24;
    localparam int NORM_BIT    = 58;
    localparam longint HALF_TURN = 180 * 65536;
    localparam longint BRG_MIN = -23040;
    localparam longint BRG_MAX = 23039;
    localparam longint C_MAX   = 8388607;
    localparam longint C_MIN   = -8388608;
    localparam int HOLD_CYCLES = 300;
    // Slowest run is roughly 1950 transactions plus the hold-off;
    // allow many times that.
    localparam int CYCLE_LIMIT = 200000;

    // atan(2^-i) in degrees, scaled by 65536
    localparam longint ATAN_STEP [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [COORD_W-1:0] gx;
        logic signed [COORD_W-1:0] gy;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
    } t_coord_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic signed [COORD_W-1:0] i_goal_x = '0;
    logic signed [COORD_W-1:0] i_goal_y = '0;
    logic signed [COORD_W-1:0] i_robot_x = '0;
    logic signed [COORD_W-1:0] i_robot_y = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [btga_pkg::BEARING_W-1:0] o_bearing;

    t_coord_pair pending_q[$];
    logic signed [btga_pkg::BEARING_W-1:0] bearing_q[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int checked_count = 0;
    int pair_count = 0;
    int coincident_count = 0;
    int in_stall_cycles = 0;

    bearing_to_goal_angle #(
        .COORD_WIDTH  (COORD_W),
        .CORDIC_STAGES(STAGES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_goal_x   (i_goal_x),
        .i_goal_y   (i_goal_y),
        .i_robot_x  (i_robot_x),
        .i_robot_y  (i_robot_y),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_bearing  (o_bearing)
    );

    always #4 i_clk = ~i_clk;

    // Compute the bearing of one position pair; return 0 when the positions coincide.
    function automatic bit predict_bearing(input logic signed [COORD_W-1:0] gx,
                                           input logic signed [COORD_W-1:0] gy,
                                           input logic signed [COORD_W-1:0] rx,
                                           input logic signed [COORD_W-1:0] ry,
                                           output logic signed [btga_pkg::BEARING_W-1:0] brg);
        longint dx, dy, sin_c, cos_c, sin_s, cos_s, ang, rounded;
        longint unsigned big;
        dx = longint'(gx) - longint'(rx);
        dy = longint'(gy) - longint'(ry);
        if (dx == 0 && dy == 0) return 1'b0;
        sin_c = -dx;
        cos_c = dy;
        ang = 0;
        // Fold the lower half-plane up, starting from plus or minus a half turn
        if (cos_c < 0) begin
            ang = (sin_c > 0) ? HALF_TURN : -HALF_TURN;
            sin_c = -sin_c;
            cos_c = -cos_c;
        end
        // Normalize so the larger magnitude lands in [2^58, 2^59)
        big = (sin_c < 0) ? longint'(-sin_c) : longint'(sin_c);
        if (cos_c > longint'(big) || -cos_c > longint'(big))
            big = (cos_c < 0) ? -cos_c : cos_c;
        while (big < (64'd1 << NORM_BIT)) begin
            big = big << 1;
            sin_c = sin_c * 2;
            cos_c = cos_c * 2;
        end
        // Rotate toward the cosine axis, accumulating the angle
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            sin_s = sin_c >>> i;
            cos_s = cos_c >>> i;
            if (sin_c >= 0) begin
                cos_c = cos_c + sin_s;
                sin_c = sin_c - cos_s;
                ang = ang + ATAN_STEP[i];
            end else begin
                cos_c = cos_c - sin_s;
                sin_c = sin_c + cos_s;
                ang = ang - ATAN_STEP[i];
            end
        end
        // Round half up to 1/128 degree and saturate
        rounded = (ang + 256) >>> 9;
        if (rounded > BRG_MAX) rounded = BRG_MAX;
        if (rounded < BRG_MIN) rounded = BRG_MIN;
        brg = btga_pkg::BEARING_W'(rounded);
        return 1'b1;
    endfunction

    task automatic push_pair(input longint gx, input longint gy, input longint rx,
                             input longint ry);
        t_coord_pair it;
        it.gx = COORD_W'(gx);
        it.gy = COORD_W'(gy);
        it.rx = COORD_W'(rx);
        it.ry = COORD_W'(ry);
        pending_q.push_back(it);
    endtask

    // Queue random pairs until the given number of them yield a bearing.
    task automatic queue_random(input int want);
        int made;
        int kind;
        longint rx, ry, dx, dy;
        made = 0;
        while (made < want) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // full-range coordinates
                push_pair(longint'($signed(COORD_W'($urandom))),
                          longint'($signed(COORD_W'($urandom))),
                          longint'($signed(COORD_W'($urandom))),
                          longint'($signed(COORD_W'($urandom))));
            end else if (kind < 75) begin
                // small offsets around a mid-range robot
                rx = longint'($urandom_range(8388607)) - 4194304;
                ry = longint'($urandom_range(8388607)) - 4194304;
                dx = longint'($urandom_range(128)) - 64;
                dy = longint'($urandom_range(128)) - 64;
                push_pair(rx + dx, ry + dy, rx, ry);
            end else if (kind < 85) begin
                // coincident positions
                rx = longint'($signed(COORD_W'($urandom)));
                ry = longint'($signed(COORD_W'($urandom)));
                push_pair(rx, ry, rx, ry);
            end else begin
                // goal well south with a small east-west offset: near the half-turn seam
                rx = longint'($urandom_range(8388607)) - 4194304;
                dx = longint'($urandom_range(32)) - 16;
                push_pair(rx + dx, longint'($urandom_range(8388607)) + C_MIN, rx,
                          longint'($urandom_range(8388607)));
            end
            if (pending_q[$].gx != pending_q[$].rx || pending_q[$].gy != pending_q[$].ry)
                made++;
        end
    endtask

    // Wait until every queued transaction is taken and every bearing has come back.
    task automatic drain();
        while (pending_q.size() != 0 || i_in_valid || bearing_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: predict on acceptance, then offer the next pending pair or idle
    always @(posedge i_clk) begin : drive_proc
        t_coord_pair it;
        logic signed [btga_pkg::BEARING_W-1:0] brg;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (o_in_stall) in_stall_cycles++;
            if (i_in_valid && !o_in_stall) begin
                pair_count++;
                if (predict_bearing(i_goal_x, i_goal_y, i_robot_x, i_robot_y, brg))
                    bearing_q.push_back(brg);
                else
                    coincident_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_q.pop_front();
                    i_goal_x <= it.gx;
                    i_goal_y <= it.gy;
                    i_robot_x <= it.rx;
                    i_robot_y <= it.ry;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once when armed
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each accepted bearing against the oldest prediction
    always @(posedge i_clk) begin : check_proc
        logic signed [btga_pkg::BEARING_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (bearing_q.size() == 0) begin
                    $display("%0t: unexpected bearing, actual %0d", $time, o_bearing);
                    fail_count++;
                end else begin
                    want = bearing_q.pop_front();
                    checked_count++;
                    if (o_bearing !== want) begin
                        $display("%0t: bearing mismatch, expected %0d actual %0d",
                                 $time, want, o_bearing);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // Directed pairs: coincident, compass points, corner extremes, half-turn seam
        push_pair(0, 0, 0, 0);
        push_pair(C_MAX, C_MIN, C_MAX, C_MIN);
        push_pair(0, 1, 0, 0);
        push_pair(0, -1, 0, 0);
        push_pair(0, C_MIN, 0, C_MAX);
        push_pair(C_MIN, C_MIN, C_MIN, C_MIN + 1);
        push_pair(1, 0, 0, 0);
        push_pair(-1, 0, 0, 0);
        push_pair(C_MAX, 0, C_MIN, 0);
        push_pair(C_MIN, 0, C_MAX, 0);
        push_pair(C_MAX, C_MAX, C_MIN, C_MIN);
        push_pair(C_MIN, C_MIN, C_MAX, C_MAX);
        push_pair(C_MIN, C_MAX, C_MAX, C_MIN);
        push_pair(C_MAX, C_MIN, C_MIN, C_MAX);
        push_pair(-1, C_MIN, 0, C_MAX);
        push_pair(1, C_MIN, 0, C_MAX);
        push_pair(1, -1, 0, 0);
        push_pair(-1, -1, 0, 0);
        push_pair(1, 1, 0, 0);
        push_pair(3, -7, -2, 5);
        push_pair(C_MAX, 1, C_MAX - 1, 0);

        // Hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // Random phases; the sender pauses for a full drain between them
        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    hold_armed = 1'b1;
                end
                1: begin
                    send_idle_pct = 79;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 79;
                end
                default: begin
                    send_idle_pct = 10;
                    stall_pct = 10;
                end
            endcase
            queue_random(434);
            drain();
        end

        repeat (2 * LATENCY) @(negedge i_clk);
        if (bearing_q.size() != 0)
            $display("%0t: %0d bearings never arrived", $time, bearing_q.size());
        $display("Checked %0d bearings from %0d position pairs (%0d coincident),",
                 checked_count, pair_count, coincident_count);
        $display("four handshake mixes plus a %0d-cycle output hold-off (%0d input stall cycles)",
                 HOLD_CYCLES, in_stall_cycles);
        if (fail_count == 0 && bearing_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
